// ----- src/ssr_pkg.sv -----
`default_nettype none

package ssr_pkg;

  // Fixed field and register widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LENREG_W    = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  // Default sizes handed to the top level
  localparam int unsigned DEF_MAX_PATTERN     = 8;
  localparam int unsigned DEF_MAX_REPLACEMENT = 8;

  // Input queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_REPL_BYTES     = 2'd2,
    CFG_REPL_LENGTH    = 2'd3
  } cfg_idx_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_REPL,
    BK_FLUSH
  } bk_state_e;

  // One classified input item
  typedef struct packed {
    logic              flush;
    logic [BYTE_W-1:0] data;
  } q_item_t;

  // Configuration as seen by the back end, lengths already clamped
  typedef struct packed {
    logic [WORD_W-1:0]   pattern;
    logic [LENREG_W-1:0] plen;
    logic [WORD_W-1:0]   repl;
    logic [LENREG_W-1:0] rlen;
  } cfg_t;

  // Byte i of a 64-bit word, byte 0 lowest
  function automatic logic [BYTE_W-1:0] byte_of(input logic [WORD_W-1:0] word,
                                                input logic [LENREG_W-1:0] i);
    return word[{i[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

// ----- src/ssr_cfg.sv -----
`default_nettype none

module ssr_cfg
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int unsigned MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_wdata_i,
  output cfg_t                      cfg_o
);

  logic [WORD_W-1:0]   pattern_q;
  logic [LENREG_W-1:0] plen_q;
  logic [WORD_W-1:0]   repl_q;
  logic [LENREG_W-1:0] rlen_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
      repl_q    <= '0;
      rlen_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_BYTES:  pattern_q <= cfg_wdata_i;
        CFG_PATTERN_LENGTH: plen_q    <= cfg_wdata_i[LENREG_W-1:0];
        CFG_REPL_BYTES:     repl_q    <= cfg_wdata_i;
        CFG_REPL_LENGTH:    rlen_q    <= cfg_wdata_i[LENREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Oversized lengths count as the maximum
  always_comb begin
    cfg_o.pattern = pattern_q;
    cfg_o.repl    = repl_q;
    cfg_o.plen    = (plen_q > LENREG_W'(MAX_PATTERN)) ? LENREG_W'(MAX_PATTERN) : plen_q;
    cfg_o.rlen    = (rlen_q > LENREG_W'(MAX_REPLACEMENT)) ? LENREG_W'(MAX_REPLACEMENT)
                                                           : rlen_q;
  end

endmodule

`default_nettype wire

// ----- src/ssr_front.sv -----
`default_nettype none

module ssr_front
  import ssr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [BYTE_W-1:0] s_axis_tdata_i,
  input  wire logic              s_axis_tuser_i,
  output q_item_t                q_item_o,
  output logic                   q_valid_o,
  input  wire logic              q_pop_i
);

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign s_axis_tready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = q_pop_i && q_valid_o;
  assign q_valid_o       = (cnt_q != '0);
  assign q_item_o        = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  // Classify and store the item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].flush <= s_axis_tuser_i;
      mem_q[wr_ptr_q].data  <= s_axis_tdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/ssr_back.sv -----
`default_nettype none

module ssr_back
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int unsigned MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire q_item_t            q_item_i,
  input  wire logic               q_valid_i,
  output logic                    q_pop_o,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [BYTE_W-1:0]       m_axis_tdata_o,
  output logic                    m_axis_tlast_o
);

  localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned RLEN_W = $clog2(MAX_REPLACEMENT + 1);

  bk_state_e         state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0] buf_q [MAX_PATTERN];
  logic [BYTE_W-1:0] buf_d [MAX_PATTERN];
  logic [RLEN_W-1:0] rep_q, rep_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic [LEN_W-1:0]  plen, rem;
  logic [RLEN_W-1:0] rlen;
  logic              p0, p1, out_free;
  logic              emit, emit_last, shift;
  logic [BYTE_W-1:0] emit_byte;

  assign plen     = cfg_i.plen[LEN_W-1:0];
  assign rlen     = cfg_i.rlen[RLEN_W-1:0];
  assign rem      = len_q - 1'b1;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Is the held window (whole, or less its first byte) a prefix of the pattern
  always_comb begin
    p0 = (len_q <= plen);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < len_q &&
          buf_q[i] != cfg_i.pattern[i*BYTE_W +: BYTE_W]) p0 = 1'b0;
    end
    p1 = (rem <= plen);
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      if (LEN_W'(i) < rem &&
          buf_q[i+1] != cfg_i.pattern[i*BYTE_W +: BYTE_W]) p1 = 1'b0;
    end
  end

  // Sequencer: append, rescan one byte a cycle while the output register is free, emit replacement or flush
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    buf_d     = buf_q;
    rep_d     = rep_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = buf_q[0];
    shift     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.flush) begin
            if (len_q != '0) state_d = BK_FLUSH;
          end else begin
            buf_d[len_q[IDX_W-1:0]] = q_item_i.data;
            len_d   = len_q + 1'b1;
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (len_q == '0) begin
          state_d = BK_IDLE;
        end else if (p0) begin
          // partial match stays held, full match is replaced
          state_d = BK_IDLE;
          if (len_q == plen) begin
            len_d = '0;
            rep_d = '0;
            if (rlen != '0) state_d = BK_REPL;
          end
        end else if (out_free) begin
          emit      = 1'b1;
          shift     = 1'b1;
          emit_last = (len_q == LEN_W'(1)) || (p1 && (rem != plen || rlen == '0));
          len_d     = rem;
        end
      end
      BK_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = byte_of(cfg_i.repl, LENREG_W'(rep_q));
          emit_last = (rep_q == rlen - 1'b1);
          rep_d     = rep_q + 1'b1;
          if (emit_last) state_d = BK_IDLE;
        end
      end
      BK_FLUSH: begin
        if (out_free) begin
          emit      = 1'b1;
          shift     = 1'b1;
          emit_last = (len_q == LEN_W'(1));
          len_d     = rem;
          if (emit_last) state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    if (shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) buf_d[i] = buf_q[i+1];
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      len_q       <= '0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ----- src/stream_search_replace_core.sv -----
`default_nettype none

// Streaming search and replace. Text bytes enter on the slave stream (tuser
// high marks a flush item), rewritten bytes leave on the master stream with
// tlast on the last byte caused by each input item. Every leftmost,
// non-overlapping occurrence of the pattern is replaced; bytes that might
// still start a match are held until decided, and a flush releases them
// unchanged. A two-item input queue separates the front from the back-end
// sequencer, which handles one item at a time: a byte is taken from the
// queue and scanned, then the sequencer releases held bytes or emits the
// replacement bytes one by one; a flush releases each held byte. The rate
// is set by the back-end sequencer, one output byte per cycle through the
// output register while the master stream is not stalled.
module stream_search_replace_core
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int unsigned MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_wdata_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [BYTE_W-1:0]    s_axis_tdata_i,  // data_byte
  input  wire logic                 s_axis_tuser_i,  // flush
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [BYTE_W-1:0]         m_axis_tdata_o,  // out_byte
  output logic                      m_axis_tlast_o   // run_last
);

  cfg_t    cfg;
  q_item_t q_item;
  logic    q_valid, q_pop;

  ssr_cfg #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_item_o        (q_item),
    .q_valid_o       (q_valid),
    .q_pop_i         (q_pop)
  );

  ssr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_item_i        (q_item),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ----- src/ssr_checker.sv -----
`default_nettype none

module ssr_checker
  import ssr_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tready_i,
  input wire logic              m_axis_tvalid_i,
  input wire logic              m_axis_tready_i,
  input wire logic [BYTE_W-1:0] m_axis_tdata_i,
  input wire logic              m_axis_tlast_i
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("output item dropped while stalled");

  // A stalled result item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
    else $error("output payload changed while stalled");

  // Reset clears the output register
  a_rst_out: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_i)
    else $error("output valid during reset");

  // The input queue is empty as reset ends
  a_rst_ready: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready_i)
    else $error("input not ready after reset");

endmodule

bind stream_search_replace_core ssr_checker u_ssr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire
